### rtl/core/hvt_pkg.sv
// Package for the homogeneous vertex transform: widths, types and reset matrix.
// Used by every module of the block; depends on nothing.

package hvt_pkg;

   // Vector and matrix geometry
   localparam int NUM_COMP   = 4;
   localparam int NUM_PAIRS  = 8;
   localparam int COMP_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int PAIR_REG_W = 2 * COMP_W;

   // Datapath widths: exact product, pair sum, full sum
   localparam int PROD_W = 2 * COMP_W;
   localparam int PSUM_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;

   // Stream and register port widths
   localparam int TDATA_W     = NUM_COMP * COMP_W;
   localparam int CSR_INDEX_W = 8;

   // Round to nearest, ties toward plus infinity
   localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) <<< (FRAC_W - 1);

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [PSUM_W-1:0] psum_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic [PAIR_REG_W-1:0]    pair_reg_type;
   typedef logic [CSR_INDEX_W-1:0]   csr_index_type;

   // Reset matrix is the identity
   localparam pair_reg_type MTX_RESET [NUM_PAIRS] = '{
      64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
   };

endpackage

### rtl/core/hvt_lane.sv
// One output-column lane: four multipliers, a pair-sum stage and a final sum.
// Depends on hvt_pkg.

module hvt_lane
   import hvt_pkg::*;
(
   input  logic     clock,
   input  logic     advance,
   input  comp_type vec  [NUM_COMP],
   input  comp_type elem [NUM_COMP],
   output sum_type  sum_biased
);

   prod_type prod_in [NUM_COMP];
   prod_type prod_ff [NUM_COMP];
   psum_type psum_lo_ff;
   psum_type psum_hi_ff;
   sum_type  sum_ff;

   // Form each exact Q32.32 product
   always_comb begin
      for (int r = 0; r < NUM_COMP; r++) begin
         prod_in[r] = PROD_W'(vec[r]) * PROD_W'(elem[r]);
      end
   end

   // Advance the three arithmetic stages together
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff    <= prod_in;
         psum_lo_ff <= PSUM_W'(prod_ff[0]) + PSUM_W'(prod_ff[1]);
         psum_hi_ff <= PSUM_W'(prod_ff[2]) + PSUM_W'(prod_ff[3]);
         sum_ff     <= SUM_W'(psum_lo_ff) + SUM_W'(psum_hi_ff) + ROUND_BIAS;
      end
   end

   assign sum_biased = sum_ff;

endmodule

### rtl/core/hvt_merge.sv
// Merge stage: rounds and saturates the lane sums, packs them, and holds them
// in an output register with a skid register behind it. Depends on hvt_pkg.

module hvt_merge
   import hvt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  sum_type            sums [NUM_COMP],
   output logic               pipe_ready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata
);

   logic [TDATA_W-1:0] packed_res;
   logic [TDATA_W-1:0] out_data_ff;
   logic [TDATA_W-1:0] skid_data_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic               skid_valid_ff;
   logic               skid_valid_in;
   logic               load;
   logic               out_free;

   // Drop the fraction guard bits and clamp to the 32-bit range
   function automatic comp_type round_sat(input sum_type s);
      logic [SUM_W-FRAC_W-COMP_W:0] top;
      comp_type                     res;
      top = s[SUM_W-1:FRAC_W+COMP_W-1];
      if (top == '0 || top == '1) begin
         res = s[FRAC_W+COMP_W-1:FRAC_W];
      end else if (s[SUM_W-1]) begin
         res = {1'b1, {(COMP_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(COMP_W-1){1'b1}}};
      end
      return res;
   endfunction

   // Pack the lanes, x in the lowest bits
   always_comb begin
      for (int c = 0; c < NUM_COMP; c++) begin
         packed_res[c*COMP_W +: COMP_W] = round_sat(sums[c]);
      end
   end

   assign pipe_ready = !skid_valid_ff;
   assign load       = in_valid && pipe_ready;
   assign out_free   = !out_valid_ff || rsp_tready;

   // Output and skid occupancy
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            skid_valid_in = 1'b0;
         end
      end else if (load) begin
         if (out_free) begin
            out_valid_in = 1'b1;
         end else begin
            skid_valid_in = 1'b1;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Move payload: skid drains first, new items fill output or skid
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (load) begin
         if (out_free) begin
            out_data_ff <= packed_res;
         end else begin
            skid_data_ff <= packed_res;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

### rtl/core/homogeneous_vertex_transform.sv
// Homogeneous 4x4 matrix-vector transform in signed Q16.16, row-vector form.
// Top level: matrix registers, lane array and merge stage; depends on hvt_pkg.
//
// One vector (x, y, z, w) enters per cycle and one transformed vector leaves
// per cycle while rsp_tready holds. Four lanes, one per output column, each
// carry four 32x32 multipliers and a two-level adder; a result passes the
// product, pair-sum, sum and output registers. Each column sum is exact,
// rounded to nearest at 16 fraction bits (ties toward plus infinity) and
// saturated to 32 bits. The matrix resets to identity and is written as
// eight 64-bit pairs through the csr port (index 0..7, other indexes
// ignored); write it only while no item is in flight. An output register
// with a skid register lets input continue while a result waits to be taken.

module homogeneous_vertex_transform
   import hvt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // req_tdata fields from bit 0: in_x, in_y, in_z, in_w (32 bits each)
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TDATA_W-1:0]   req_tdata,
   // rsp_tdata fields from bit 0: out_x, out_y, out_z, out_w (32 bits each)
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [TDATA_W-1:0]   rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  csr_index_type        csr_index,
   input  pair_reg_type         csr_data
);

   pair_reg_type mtx_ff [NUM_PAIRS];
   comp_type     vec       [NUM_COMP];
   comp_type     lane_elem [NUM_COMP][NUM_COMP];
   sum_type      lane_sum  [NUM_COMP];
   logic         advance;
   logic         v1_ff;
   logic         v2_ff;
   logic         v3_ff;

   // Matrix registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mtx_ff <= MTX_RESET;
      end else if (csr_valid && csr_index < CSR_INDEX_W'(NUM_PAIRS)) begin
         mtx_ff[csr_index[$clog2(NUM_PAIRS)-1:0]] <= csr_data;
      end
   end

   // Unpack the input vector
   always_comb begin
      for (int r = 0; r < NUM_COMP; r++) begin
         vec[r] = req_tdata[r*COMP_W +: COMP_W];
      end
   end

   // Route column c of each row to lane c
   for (genvar c = 0; c < NUM_COMP; c++) begin : g_col
      for (genvar r = 0; r < NUM_COMP; r++) begin : g_row
         localparam int PairIdx = r * 2 + c / 2;
         localparam int HalfLsb = (c % 2) * COMP_W;
         assign lane_elem[c][r] = mtx_ff[PairIdx][HalfLsb +: COMP_W];
      end

      hvt_lane u_lane (
         .clock      (clock),
         .advance    (advance),
         .vec        (vec),
         .elem       (lane_elem[c]),
         .sum_biased (lane_sum[c])
      );
   end

   // Track items through the lane stages
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   hvt_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v3_ff),
      .sums       (lane_sum),
      .pipe_ready (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### test/homogeneous_vertex_transform_tb.sv
// Self-checking testbench for the homogeneous vertex transform.
// Drives vectors and matrix writes, predicts each result in place and
// compares it field by field; depends on hvt_pkg and the top level only.

module homogeneous_vertex_transform_tb;
   import hvt_pkg::*;

   localparam int PIPE_LATENCY  = 4;
   localparam int ACC_W         = SUM_W + 2;
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_ITEMS   = 190;
   localparam int IDLE_PERCENT  = 35;
   localparam int TIMEOUT_TICKS = 12 * 300_000;

   localparam comp_type COMP_MAX = 32'sh7FFF_FFFF;
   localparam comp_type COMP_MIN = 32'sh8000_0000;
   localparam comp_type COMP_ONE = 32'sh0001_0000;
   localparam comp_type COMP_HALF = 32'sh0000_8000;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);
   localparam logic signed [ACC_W-1:0] SAT_HIGH   = ACC_W'(COMP_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LOW    = ACC_W'(COMP_MIN);

   localparam comp_type SPECIAL_COMPS [5] = '{COMP_MAX, COMP_MIN, 32'sh0, COMP_ONE, -32'sh1};

   // x in the lowest bits, w in the highest
   typedef comp_type [NUM_COMP-1:0] vertex_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [TDATA_W-1:0] req_tdata;     // from bit 0: in_x, in_y, in_z, in_w
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [TDATA_W-1:0] rsp_tdata;     // from bit 0: out_x, out_y, out_z, out_w
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   pair_reg_type  csr_data;

   comp_type   matrix_shadow [NUM_COMP][NUM_COMP];
   vertex_type predicted_vertices [$];
   int         error_count;
   bit         feed_steady;
   bit         sink_steady;

   string FIELD_NAMES [NUM_COMP] = '{"out_x", "out_y", "out_z", "out_w"};

   homogeneous_vertex_transform i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Multiply by the shadow matrix: exact sum, round half up, saturate
   function automatic vertex_type transform_vertex(input vertex_type v);
      vertex_type              result;
      logic signed [ACC_W-1:0] acc;
      prod_type                prod;
      comp_type                elem;
      comp_type                comp;
      int                      r;
      int                      c;
      for (c = 0; c < NUM_COMP; c++) begin
         acc = ROUND_HALF;
         for (r = 0; r < NUM_COMP; r++) begin
            elem = matrix_shadow[r][c];
            comp = v[r];
            prod = elem * comp;
            acc  = acc + prod;
         end
         acc = acc >>> FRAC_W;
         if (acc > SAT_HIGH) begin
            result[c] = COMP_MAX;
         end else if (acc < SAT_LOW) begin
            result[c] = COMP_MIN;
         end else begin
            result[c] = acc[COMP_W-1:0];
         end
      end
      return result;
   endfunction

   function automatic vertex_type make_vertex(input comp_type x, input comp_type y,
                                              input comp_type z, input comp_type w);
      return {w, z, y, x};
   endfunction

   // Tame values stay within +-4.0; otherwise mix full range, +-4.0, specials and +-256
   function automatic comp_type rand_comp(input bit tame);
      int unsigned pick;
      pick = tame ? 1 : $urandom_range(3);
      case (pick)
         0: return comp_type'($urandom);
         1: return comp_type'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
         2: return SPECIAL_COMPS[$urandom_range(4)];
         default: return comp_type'($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
      endcase
   endfunction

   function automatic vertex_type rand_vertex();
      return make_vertex(rand_comp(1'b0), rand_comp(1'b0), rand_comp(1'b0), rand_comp(1'b0));
   endfunction

   // Offer one vector after random idle unless feed_steady; record its prediction
   task automatic send_vertex(input vertex_type v);
      while (!feed_steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted_vertices.push_back(transform_vertex(v));
      @(negedge clock);
   endtask

   // Stop feeding and hold until every predicted result has drained
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (predicted_vertices.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 2) @(negedge clock);
   endtask

   // Write one matrix pair; out-of-range indexes leave the matrix alone
   task automatic write_pair(input csr_index_type index, input pair_reg_type data);
      int row;
      int col;
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index < NUM_PAIRS) begin
         row = index / 2;
         col = 2 * (index % 2);
         matrix_shadow[row][col]     = data[COMP_W-1:0];
         matrix_shadow[row][col + 1] = data[PAIR_REG_W-1:COMP_W];
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Load a matrix with one value on the diagonal and another elsewhere
   task automatic load_uniform(input comp_type diag, input comp_type off);
      int k;
      int row;
      for (k = 0; k < NUM_PAIRS; k++) begin
         row = k / 2;
         write_pair(csr_index_type'(k), {(row == 2 * (k % 2) + 1) ? diag : off,
                                         (row == 2 * (k % 2))     ? diag : off});
      end
   endtask

   // Reset matrix passes the field extremes through unchanged
   task automatic test_identity_extremes();
      send_vertex(make_vertex(0, 0, 0, 0));
      send_vertex(make_vertex(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
      send_vertex(make_vertex(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN));
      send_vertex(make_vertex(COMP_MAX, COMP_MIN, 32'sh1, -32'sh1));
      send_vertex(make_vertex(32'sh5555_5555, 32'shAAAA_AAAA, COMP_ONE, -COMP_ONE));
   endtask

   // Half-unit products land exactly on ties; ties round toward plus infinity
   task automatic test_rounding_ties();
      wait_idle();
      load_uniform(COMP_HALF, 0);
      send_vertex(make_vertex(32'sh1, -32'sh1, 32'sh3, -32'sh3));
      send_vertex(make_vertex(32'sh2, -32'sh2, COMP_MAX, COMP_MIN));
      send_vertex(make_vertex(32'sh0001_0001, -32'sh0001_0001, 32'sh7, -32'sh7));
      wait_idle();
      load_uniform(-COMP_HALF, 32'sh0000_0001);
      send_vertex(make_vertex(32'sh1, -32'sh1, 32'sh3, -32'sh3));
      send_vertex(make_vertex(32'sh0000_8000, -32'sh0000_8000, 32'sh0, 32'sh5));
      send_vertex(make_vertex(COMP_MAX, COMP_MIN, 32'sh1, 32'sh1));
   endtask

   // Extreme matrices drive every column past both saturation limits
   task automatic test_saturation();
      wait_idle();
      load_uniform(COMP_MAX, COMP_MAX);
      send_vertex(make_vertex(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
      send_vertex(make_vertex(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN));
      wait_idle();
      load_uniform(COMP_MIN, COMP_MIN);
      send_vertex(make_vertex(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN));
      send_vertex(make_vertex(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN));
      send_vertex(make_vertex(COMP_ONE, 32'sh0, 32'sh0, 32'sh0));
   endtask

   // Writes past the last pair must not disturb the matrix
   task automatic test_bad_index();
      wait_idle();
      load_uniform(COMP_ONE, 0);
      write_pair(csr_index_type'(NUM_PAIRS), {32'shDEAD_BEEF, 32'sh1234_5678});
      write_pair(8'hFF, {COMP_MAX, COMP_MIN});
      write_pair(8'h87, {COMP_MIN, COMP_MAX});
      send_vertex(make_vertex(32'sh1234_5678, -32'sh0765_4321, COMP_ONE, COMP_ONE));
      send_vertex(make_vertex(COMP_MAX, COMP_MIN, 32'sh0, -COMP_ONE));
      send_vertex(rand_vertex());
   endtask

   // Random matrices per phase, tame and wild in turn, random vectors
   task automatic test_random_phases();
      int phase;
      int k;
      int n;
      bit tame;
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         tame = (phase % 2 == 0);
         for (k = 0; k < NUM_PAIRS; k++) begin
            write_pair(csr_index_type'(k), {rand_comp(tame), rand_comp(tame)});
         end
         write_pair(csr_index_type'($urandom_range(255, NUM_PAIRS)),
                    {rand_comp(1'b0), rand_comp(1'b0)});
         // run one phase with both sides busy every cycle
         feed_steady = (phase == 3);
         sink_steady = (phase == 3);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            send_vertex(rand_vertex());
         end
      end
      feed_steady = 1'b0;
      sink_steady = 1'b0;
   endtask

   // Stall the result side at random unless sink_steady is set
   always @(negedge clock) begin
      rsp_tready = sink_steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_result
      vertex_type want;
      vertex_type got;
      int         i;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_vertices.size() == 0) begin
            $error("result arrived with no item pending: %h", rsp_tdata);
            error_count++;
         end else begin
            want = predicted_vertices.pop_front();
            got  = rsp_tdata;
            for (i = 0; i < NUM_COMP; i++) begin
               if (got[i] !== want[i]) begin
                  $error("%s expected %h actual %h", FIELD_NAMES[i], want[i], got[i]);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin : run_tests
      int r;
      int c;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      error_count = 0;
      feed_steady = 1'b0;
      sink_steady = 1'b0;
      for (r = 0; r < NUM_COMP; r++) begin
         for (c = 0; c < NUM_COMP; c++) begin
            matrix_shadow[r][c] = (r == c) ? COMP_ONE : 32'sh0;
         end
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_identity_extremes();
      test_rounding_ties();
      test_saturation();
      test_bad_index();
      test_random_phases();

      wait_idle();
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Bound the run in case the block stops responding
   initial begin
      #(TIMEOUT_TICKS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
